### sv/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg: shared definitions for the integer execute stage
// Opcodes, widths, store sizes and the structs passed between the modules.
// ----------------------------------------------------------------------------
package msie_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_WORDS = 1024;
  localparam int STK_AW      = $clog2(STACK_WORDS);
  localparam int MAX_LINES   = 2048;
  localparam int LINE_W      = $clog2(MAX_LINES);
  localparam int PC_W        = LINE_W + 1;
  localparam int REG_AW      = 5;
  localparam int OP_W        = 5;
  localparam int IDX_W       = DATA_W + 2;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 56;

  localparam logic [REG_AW-1:0] SP_REG = REG_AW'(29);

  localparam logic [OP_W-1:0] OP_NOP  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_ADD  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_ADDI = OP_W'(2);
  localparam logic [OP_W-1:0] OP_SUB  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_MUL  = OP_W'(4);
  localparam logic [OP_W-1:0] OP_AND  = OP_W'(5);
  localparam logic [OP_W-1:0] OP_ANDI = OP_W'(6);
  localparam logic [OP_W-1:0] OP_OR   = OP_W'(7);
  localparam logic [OP_W-1:0] OP_ORI  = OP_W'(8);
  localparam logic [OP_W-1:0] OP_NOR  = OP_W'(9);
  localparam logic [OP_W-1:0] OP_SLT  = OP_W'(10);
  localparam logic [OP_W-1:0] OP_SLTI = OP_W'(11);
  localparam logic [OP_W-1:0] OP_LW   = OP_W'(12);
  localparam logic [OP_W-1:0] OP_SW   = OP_W'(13);
  localparam logic [OP_W-1:0] OP_BEQ  = OP_W'(14);
  localparam logic [OP_W-1:0] OP_BNE  = OP_W'(15);
  localparam logic [OP_W-1:0] OP_J    = OP_W'(16);
  localparam logic [OP_W-1:0] OP_HALT = OP_W'(17);

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [DATA_W-1:0] val;
  } rf_wr_t;

  typedef struct packed {
    logic [PC_W-1:0]   npc;
    logic              wr_en;
    logic [REG_AW-1:0] wr_idx;
    logic [DATA_W-1:0] wr_val;
    logic              ld;
    logic              st;
    logic              halted;
    logic              done;
    logic              aerr;
    logic [STK_AW-1:0] mem_idx;
  } exe_res_t;

endpackage

### sv/msie_regfile.sv
// ----------------------------------------------------------------------------
// msie_regfile: 32 x 32 register file
// Two copies for three registered read ports; per-entry valid bits give the
// all-zero reset. Register 0 is never written and so always reads zero.
// ----------------------------------------------------------------------------
module msie_regfile
  import msie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [REG_AW-1:0] rd_addr_a,
  input  logic [REG_AW-1:0] rd_addr_b,
  input  logic [REG_AW-1:0] rd_addr_c,
  input  rf_wr_t            wr,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b,
  output logic [DATA_W-1:0] rd_c
);

  localparam int DEPTH = 2 ** REG_AW;

  logic [DATA_W-1:0] mem_ab [DEPTH];
  logic [DATA_W-1:0] mem_c  [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] qa_r, qb_r, qc_r;
  logic              va_r, vb_r, vc_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ab[wr.idx] <= wr.val;
      mem_c[wr.idx]  <= wr.val;
    end
    if (rd_en) begin
      qa_r <= mem_ab[rd_addr_a];
      qb_r <= mem_ab[rd_addr_b];
      qc_r <= mem_c[rd_addr_c];
      va_r <= vld_r[rd_addr_a];
      vb_r <= vld_r[rd_addr_b];
      vc_r <= vld_r[rd_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.idx] <= 1'b1;
    end
  end

  assign rd_a = va_r ? qa_r : '0;
  assign rd_b = vb_r ? qb_r : '0;
  assign rd_c = vc_r ? qc_r : '0;

endmodule

### sv/msie_exec.sv
// ----------------------------------------------------------------------------
// msie_exec: instruction execute logic
// ALU, branch resolution, stack index and bounds check, pc and halt update.
// ----------------------------------------------------------------------------
module msie_exec
  import msie_pkg::*;
(
  input  logic [OP_W-1:0]   op,
  input  logic [REG_AW-1:0] ra,
  input  logic [DATA_W-1:0] va,
  input  logic [DATA_W-1:0] vb,
  input  logic [DATA_W-1:0] vc,
  input  logic [DATA_W-1:0] imm,
  input  logic [LINE_W-1:0] tgt,
  input  logic [DATA_W-1:0] sp,
  input  logic [PC_W-1:0]   pc,
  input  logic              halt,
  input  logic [LINE_W-1:0] last,
  output exe_res_t          res
);

  localparam logic signed [IDX_W-1:0] STK_HI = IDX_W'(STACK_WORDS);
  localparam logic signed [IDX_W-1:0] STK_LO = -STK_HI;

  logic                     active;
  logic [PC_W-1:0]          pc_inc;
  logic [PC_W-1:0]          tgt_inc;
  logic [DATA_W-1:0]        prod;
  logic signed [IDX_W-1:0]  sum;
  logic signed [IDX_W-1:0]  sum_neg;
  logic                     rnd;
  logic                     idx_err;
  logic [STK_AW-1:0]        stk_idx;

  assign active  = !halt && (pc <= {1'b0, last});
  assign pc_inc  = pc + PC_W'(1);
  assign tgt_inc = {1'b0, tgt} + PC_W'(1);
  assign prod    = vb * vc;

  // sp/4 rounds toward zero: add one when sp is negative with a remainder
  assign rnd     = sp[DATA_W-1] & (|sp[1:0]);
  assign sum     = $signed({{2{imm[DATA_W-1]}}, imm})
                 + $signed({{4{sp[DATA_W-1]}}, sp[DATA_W-1:2]})
                 + $signed({{(IDX_W-1){1'b0}}, rnd});
  assign sum_neg = -sum;
  assign idx_err = (sum >= STK_HI) || (sum <= STK_LO);
  assign stk_idx = sum[IDX_W-1] ? sum_neg[STK_AW-1:0] : sum[STK_AW-1:0];

  always_comb begin
    res         = '0;
    res.halted  = halt;
    res.npc     = pc;
    res.mem_idx = stk_idx;
    if (active) begin
      res.npc = pc_inc;
      unique case (op) inside
        OP_ADD:  begin res.wr_en = 1'b1; res.wr_val = vb + vc;  end
        OP_ADDI: begin res.wr_en = 1'b1; res.wr_val = vb + imm; end
        OP_SUB:  begin res.wr_en = 1'b1; res.wr_val = vb - vc;  end
        OP_MUL:  begin res.wr_en = 1'b1; res.wr_val = prod;     end
        OP_AND:  begin res.wr_en = 1'b1; res.wr_val = vb & vc;  end
        OP_ANDI: begin res.wr_en = 1'b1; res.wr_val = vb & imm; end
        OP_OR:   begin res.wr_en = 1'b1; res.wr_val = vb | vc;  end
        OP_ORI:  begin res.wr_en = 1'b1; res.wr_val = vb | imm; end
        OP_NOR:  begin res.wr_en = 1'b1; res.wr_val = ~(vb | vc); end
        OP_SLT: begin
          res.wr_en  = 1'b1;
          res.wr_val = DATA_W'($signed(vb) < $signed(vc));
        end
        OP_SLTI: begin
          res.wr_en  = 1'b1;
          res.wr_val = DATA_W'($signed(vb) < $signed(imm));
        end
        OP_LW, OP_SW: begin
          res.aerr = idx_err;
          if (op == OP_LW) begin
            res.wr_en = !idx_err;
            res.ld    = !idx_err;
          end else begin
            res.st    = !idx_err;
          end
        end
        OP_BEQ: begin
          if (va == vb) res.npc = tgt_inc;
        end
        OP_BNE: begin
          if (va != vb) res.npc = tgt_inc;
        end
        OP_J: begin
          res.npc = tgt_inc;
        end
        OP_HALT: begin
          res.halted = 1'b1;
          res.npc    = pc;
        end
        default: begin
        end
      endcase
    end
    if (res.wr_en && (ra == '0)) begin
      res.wr_en  = 1'b0;
      res.wr_val = '0;
      res.ld     = 1'b0;
    end
    res.wr_idx = res.wr_en ? ra : '0;
    res.done   = res.npc > {1'b0, last};
  end

endmodule

### sv/mips_subset_instruction_execute.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute: integer execute stage
// Executes one pre-decoded instruction per transfer against a register file
// and a word stack store.
// ----------------------------------------------------------------------------
// One instruction is taken every clock unless out_tready stalls the output or
// the clearing pass runs; its result passes the operand read stage, then the
// result register. The lw data comes from the stack store's registered read,
// which lines up with the result register; register write-back happens on the
// result transfer and is forwarded to the next instruction, so dependent
// instructions also issue back to back. After reset the stack store is cleared
// one word a cycle, with in_tready low; configuration writes are taken throughout.
module mips_subset_instruction_execute
  import msie_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [10:0]      cfg_wr_data,  // program_length
  input  logic             in_tvalid,
  output logic             in_tready,
  // req_type[4:0], reg_a[9:5], reg_b[14:10], reg_c[19:15], immediate[51:20],
  // branch_target[62:52], zero[63]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // next_pc[11:0], reg_write_en[12], reg_write_index[17:13],
  // reg_write_value[49:18], halted[50], done_res[51], address_error[52], zero[55:53]
  output logic [OUT_W-1:0] out_tdata
);

  logic              in_fire, out_fire, adv, s1_go;
  logic              s1_vld_r, s2_vld_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [REG_AW-1:0] s1_ra_r, s1_rb_r, s1_rc_r;
  logic [DATA_W-1:0] s1_imm_r;
  logic [LINE_W-1:0] s1_tgt_r;
  exe_res_t          s2_res_r;
  exe_res_t          exe;
  logic [LINE_W-1:0] plen_r;
  logic [PC_W-1:0]   pc_r;
  logic              halt_r;
  logic [DATA_W-1:0] sp_r, sp_fwd;
  rf_wr_t            wb_r, s2_wr, rf_wr;
  logic [DATA_W-1:0] rf_a, rf_b, rf_c;
  logic [DATA_W-1:0] va, vb, vc;
  logic [DATA_W-1:0] stk_mem [STACK_WORDS];
  logic [DATA_W-1:0] stk_q_r;
  logic              stk_we, stk_re;
  logic [STK_AW-1:0] stk_waddr;
  logic [DATA_W-1:0] stk_wdata;
  logic              clr_busy_r;
  logic [STK_AW-1:0] clr_addr_r;

  function automatic logic [DATA_W-1:0] fwd(input logic [REG_AW-1:0] a,
                                            input logic [DATA_W-1:0] rfv,
                                            input rf_wr_t s2w,
                                            input rf_wr_t wb);
    logic [DATA_W-1:0] v;
    v = rfv;
    if (s2w.en && (s2w.idx == a)) begin
      v = s2w.val;
    end else if (wb.en && (wb.idx == a)) begin
      v = wb.val;
    end
    return v;
  endfunction

  assign adv       = !s2_vld_r || out_tready;
  assign in_tready = !clr_busy_r && (!s1_vld_r || adv);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = s2_vld_r && out_tready;
  assign s1_go     = s1_vld_r && adv;

  // write-back of the item in the result register
  assign s2_wr.en  = s2_vld_r && s2_res_r.wr_en;
  assign s2_wr.idx = s2_res_r.wr_idx;
  assign s2_wr.val = s2_res_r.ld ? stk_q_r : s2_res_r.wr_val;
  assign rf_wr     = out_fire ? s2_wr : '0;

  msie_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_tdata[9:5]),
    .rd_addr_b (in_tdata[14:10]),
    .rd_addr_c (in_tdata[19:15]),
    .wr        (rf_wr),
    .rd_a      (rf_a),
    .rd_b      (rf_b),
    .rd_c      (rf_c)
  );

  assign va     = fwd(s1_ra_r, rf_a, s2_wr, wb_r);
  assign vb     = fwd(s1_rb_r, rf_b, s2_wr, wb_r);
  assign vc     = fwd(s1_rc_r, rf_c, s2_wr, wb_r);
  assign sp_fwd = (s2_wr.en && (s2_wr.idx == SP_REG)) ? s2_wr.val : sp_r;

  msie_exec u_exec (
    .op   (s1_op_r),
    .ra   (s1_ra_r),
    .va   (va),
    .vb   (vb),
    .vc   (vc),
    .imm  (s1_imm_r),
    .tgt  (s1_tgt_r),
    .sp   (sp_fwd),
    .pc   (pc_r),
    .halt (halt_r),
    .last (plen_r),
    .res  (exe)
  );

  // stack store: clearing pass after reset, then at most one access per item
  assign stk_we    = clr_busy_r || (s1_go && exe.st);
  assign stk_re    = s1_go && exe.ld;
  assign stk_waddr = clr_busy_r ? clr_addr_r : exe.mem_idx;
  assign stk_wdata = clr_busy_r ? '0 : va;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q_r <= stk_mem[exe.mem_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + STK_AW'(1);
      if (clr_addr_r == STK_AW'(STACK_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_tdata[4:0];
      s1_ra_r  <= in_tdata[9:5];
      s1_rb_r  <= in_tdata[14:10];
      s1_rc_r  <= in_tdata[19:15];
      s1_imm_r <= in_tdata[51:20];
      s1_tgt_r <= in_tdata[62:52];
    end
    if (s1_go) begin
      s2_res_r <= exe;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      plen_r   <= '0;
      pc_r     <= PC_W'(1);
      halt_r   <= 1'b0;
      sp_r     <= '0;
      wb_r     <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        s2_vld_r <= s1_vld_r;
      end
      if (cfg_wr_en) begin
        plen_r <= cfg_wr_data;
      end
      if (s1_go) begin
        pc_r   <= exe.npc;
        halt_r <= exe.halted;
      end
      if (out_fire) begin
        wb_r <= rf_wr;
      end
      if (rf_wr.en && (rf_wr.idx == SP_REG)) begin
        sp_r <= rf_wr.val;
      end
    end
  end

  assign out_tvalid = s2_vld_r;
  assign out_tdata  = {3'b000, s2_res_r.aerr, s2_res_r.done, s2_res_r.halted,
                       s2_wr.val, s2_res_r.wr_idx, s2_res_r.wr_en, s2_res_r.npc};

endmodule
